// ===== hw/rtl/arc_pkg.sv =====
// shared types and codes of the arp resolver cache
// no dependencies; used by the cell, the chain, the top level and the checker
package arc_pkg;

	localparam int IN_DATA_W  = 288;
	localparam int OUT_DATA_W = 168;
	localparam int CFG_DATA_W = 48;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_SEND  = 2'd2;
	localparam logic [1:0] CMD_ARP   = 2'd3;

	localparam logic [2:0] KIND_READY  = 3'd0;
	localparam logic [2:0] KIND_SENDTO = 3'd1;
	localparam logic [2:0] KIND_FAIL   = 3'd2;
	localparam logic [2:0] KIND_QUERY  = 3'd3;
	localparam logic [2:0] KIND_REPLY  = 3'd4;

	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY   = 16'd0;

	localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
	localparam logic [1:0] CFG_OWN_IP   = 2'd1;
	localparam logic [1:0] CFG_LIFETIME = 2'd2;

	localparam logic [31:0] LIFETIME_RST = 32'd300;

	// one cached pair with its remaining life
	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] remaining;
	} entry_t;

	// first field in the highest bits
	typedef struct packed {
		logic [47:0] frame_source_mac;
		logic [31:0] target_ip;
		logic [47:0] target_mac;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [15:0] arp_operation;
		logic [31:0] request_ip;
		logic [31:0] elapsed;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  pad;
		logic        table_full;
		logic [31:0] reply_sender_ip;
		logic [47:0] reply_sender_mac;
		logic [47:0] out_mac;
		logic [31:0] out_ip;
	} out_item_t;

	// shift and tail write control broadcast along the chain
	typedef struct packed {
		logic shift;
		logic wr_en;
	} chain_ctl_t;

endpackage

// ===== hw/rtl/arc_cell.sv =====
// one cache cell: holds an entry, takes its right neighbor on shift,
// or the pushed entry when the tail write addresses it; uses arc_pkg
module arc_cell #(
	parameter int IDX_W = 4,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  arc_pkg::chain_ctl_t ctl,
	input  logic [IDX_W-1:0]    wr_idx,
	input  arc_pkg::entry_t     wr_data,
	input  arc_pkg::entry_t     next_data,
	output arc_pkg::entry_t     data
);
	import arc_pkg::*;

	entry_t data_q;
	logic   hit;

	assign hit  = ctl.wr_en && (wr_idx == IDX_W'(IDX));
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (hit) begin
			data_q <= wr_data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

endmodule

// ===== hw/rtl/arc_chain.sv =====
// row of cache cells shifting toward the head, entries in insertion order
// depends on arc_pkg and arc_cell
module arc_chain #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                clk,
	input  arc_pkg::chain_ctl_t ctl,
	input  logic [IDX_W-1:0]    wr_idx,
	input  arc_pkg::entry_t     wr_data,
	output arc_pkg::entry_t     head
);
	import arc_pkg::*;

	entry_t cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t nbr;
		if (i == DEPTH - 1) begin : g_tail
			assign nbr = wr_data;
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end
		arc_cell #(
			.IDX_W (IDX_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.wr_idx    (wr_idx),
			.wr_data   (wr_data),
			.next_data (nbr),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

// ===== hw/rtl/arp_resolver_cache_top.sv =====
// tick, query and send requests walk the n cached entries one cell per cycle,
// then the emit state registers the result; arp packets go straight to the emit state
// new requests are taken only in idle, after emit (and fail, for a missed send)
// reset clears the entry count, the control state and the output valid flag;
// own_mac and own_ip reset to 0, entry_lifetime to 300
// depends on arc_pkg and arc_chain
module arp_resolver_cache_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [arc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// elapsed, request_ip, arp_operation, sender_mac, sender_ip, target_mac,
	// target_ip, frame_source_mac
	input  logic [arc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// command
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_ip, out_mac, reply_sender_mac, reply_sender_ip, table_full, zero pad
	output logic [arc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// out_kind
	output logic [2:0]                       m_axis_tuser,
	output logic                             m_axis_tlast
);
	import arc_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_FAIL = 4'b1000
	} state_t;

	state_t     state_q, state_nxt;
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic [31:0] lifetime_q;

	in_item_t   item_q;
	logic [1:0] cmd_q;
	logic [CNT_W-1:0] count_q, count_nxt, cnt_m1;
	logic [CNT_W-1:0] scan_left_q;
	logic       found_q;
	logic [47:0] found_mac_q;

	logic       out_valid_q;
	out_item_t  out_data_q;
	logic [2:0] out_kind_q;
	logic       out_last_q;

	chain_ctl_t ctl;
	logic [IDX_W-1:0] wr_idx;
	entry_t     wr_data, head;

	logic       in_fire, out_free, keep, full, load_out;
	logic       em_valid, em_last, em_insert, em_two;
	logic [2:0] em_kind;
	out_item_t  em_data, fail_data;
	entry_t     ins_entry;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign full          = (count_q == CNT_W'(TABLE_DEPTH));
	assign cnt_m1        = count_q - CNT_W'(1);

	arc_chain #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.head    (head)
	);

	// head entry is checked and pushed back to the tail unless it expires
	assign keep = (cmd_q != CMD_TICK) || (head.remaining >= item_q.elapsed);

	// result of the current request
	always_comb begin
		em_valid  = 1'b0;
		em_last   = 1'b1;
		em_insert = 1'b0;
		em_two    = 1'b0;
		em_kind   = KIND_READY;
		em_data   = '0;
		ins_entry = '0;
		ins_entry.remaining = lifetime_q;
		unique case (cmd_q)
			CMD_TICK: begin
				em_valid = 1'b0;
			end
			CMD_QUERY, CMD_SEND: begin
				em_valid       = 1'b1;
				em_data.out_ip = item_q.request_ip;
				if (found_q) begin
					em_kind = (cmd_q == CMD_SEND) ? KIND_SENDTO : KIND_READY;
					if (cmd_q == CMD_SEND) begin
						em_data.out_mac = found_mac_q;
					end
				end else begin
					em_kind                  = KIND_QUERY;
					em_data.out_mac          = BCAST_MAC;
					em_data.reply_sender_mac = own_mac_q;
					em_data.reply_sender_ip  = own_ip_q;
					em_two                   = (cmd_q == CMD_SEND);
					em_last                  = (cmd_q != CMD_SEND);
				end
			end
			CMD_ARP: begin
				if (item_q.arp_operation == ARP_OP_REQUEST && item_q.target_ip == own_ip_q) begin
					em_valid                 = 1'b1;
					em_insert                = 1'b1;
					em_kind                  = KIND_REPLY;
					em_data.out_ip           = item_q.target_ip;
					em_data.out_mac          = item_q.frame_source_mac;
					em_data.reply_sender_mac = item_q.sender_mac;
					em_data.reply_sender_ip  = item_q.sender_ip;
					em_data.table_full       = full;
					ins_entry.ip             = item_q.sender_ip;
					ins_entry.mac            = item_q.sender_mac;
				end else if (item_q.arp_operation == ARP_OP_REPLY &&
					item_q.sender_mac == own_mac_q) begin
					em_valid           = 1'b1;
					em_insert          = 1'b1;
					em_kind            = KIND_READY;
					em_data.out_ip     = item_q.target_ip;
					em_data.table_full = full;
					ins_entry.ip       = item_q.target_ip;
					ins_entry.mac      = item_q.target_mac;
				end
			end
			default: begin
				em_valid = 1'b0;
			end
		endcase
		fail_data        = '0;
		fail_data.out_ip = item_q.request_ip;
	end

	// chain control, next state and count
	always_comb begin
		ctl.shift = 1'b0;
		ctl.wr_en = 1'b0;
		wr_idx    = cnt_m1[IDX_W-1:0];
		wr_data   = head;
		count_nxt = count_q;
		state_nxt = state_q;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (s_axis_tuser == CMD_ARP || count_q == '0) begin
						state_nxt = ST_EMIT;
					end else begin
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ctl.shift = 1'b1;
				ctl.wr_en = keep;
				if (cmd_q == CMD_TICK) begin
					wr_data.remaining = head.remaining - item_q.elapsed;
				end
				if (!keep) begin
					count_nxt = cnt_m1;
				end
				if (scan_left_q == CNT_W'(1)) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				wr_idx  = count_q[IDX_W-1:0];
				wr_data = ins_entry;
				if (!em_valid) begin
					state_nxt = ST_IDLE;
				end else if (out_free) begin
					load_out = 1'b1;
					if (em_insert && !full) begin
						ctl.wr_en = 1'b1;
						count_nxt = count_q + CNT_W'(1);
					end
					state_nxt = em_two ? ST_FAIL : ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			own_mac_q   <= '0;
			own_ip_q    <= '0;
			lifetime_q  <= LIFETIME_RST;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_OWN_MAC:  own_mac_q  <= cfg_data;
					CFG_OWN_IP:   own_ip_q   <= cfg_data[31:0];
					CFG_LIFETIME: lifetime_q <= cfg_data[31:0];
					default:      ;
				endcase
			end
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q      <= in_item_t'(s_axis_tdata);
			cmd_q       <= s_axis_tuser;
			scan_left_q <= count_q;
			found_q     <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			scan_left_q <= scan_left_q - CNT_W'(1);
			if (!found_q && head.ip == item_q.request_ip) begin
				found_q     <= 1'b1;
				found_mac_q <= head.mac;
			end
		end
		if (load_out) begin
			if (state_q == ST_FAIL) begin
				out_data_q <= fail_data;
				out_kind_q <= KIND_FAIL;
				out_last_q <= 1'b1;
			end else begin
				out_data_q <= em_data;
				out_kind_q <= em_kind;
				out_last_q <= em_last;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== hw/rtl/arc_checker.sv =====
// port-level checks of the arp resolver cache and their bind to the top level
// depends on arc_pkg and arp_resolver_cache_top
module arc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [arc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [2:0]                     m_axis_tuser,
	input logic                           m_axis_tlast
);
	import arc_pkg::*;

	out_item_t res;

	assign res = out_item_t'(m_axis_tdata);

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// send failed always closes the request
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_FAIL |-> m_axis_tlast)
		else $error("send failed without last");

	// an emitted query is broadcast
	a_query_bcast: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_QUERY |-> res.out_mac == BCAST_MAC)
		else $error("query not broadcast");

	// a non-final query is followed by the send failure of the same ip
	a_query_then_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_QUERY && !m_axis_tlast
		|=> !m_axis_tvalid || (m_axis_tuser == KIND_FAIL && res.out_ip == $past(res.out_ip)))
		else $error("query of a send not followed by its failure");

endmodule

bind arp_resolver_cache_top arc_checker u_arc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb.sv =====
// self-checking bench for arp_resolver_cache_top: directed cases, then random phases
// predicts every response from its own copy of the cache and compares in order
// depends on arc_pkg and the rtl of arp_resolver_cache_top
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arc_pkg::*;

	localparam int TABLE_DEPTH  = 16;
	localparam int QUIET_CYCLES = TABLE_DEPTH + 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int GAP_PCT      = 12;
	localparam int MAX_REPORTS  = 10;
	localparam int POOL_SIZE    = 6;

	localparam logic [15:0] ARP_OP_OTHER = 16'd2;

	typedef struct packed {
		logic [2:0] kind;
		out_item_t  data;
		logic       last;
	} response_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index      = CFG_OWN_MAC;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;
	logic                  s_axis_tvalid  = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;
	logic [1:0]            s_axis_tuser   = CMD_TICK;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [2:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	// local copy of configuration and cache contents
	logic [47:0] own_mac_q  = '0;
	logic [31:0] own_ip_q   = '0;
	logic [31:0] lifetime_q = LIFETIME_RST;
	int          cache_count = 0;
	logic [31:0] cache_ip   [TABLE_DEPTH];
	logic [47:0] cache_mac  [TABLE_DEPTH];
	logic [31:0] cache_life [TABLE_DEPTH];

	response_t   pending_responses [$];
	logic [31:0] ip_pool [POOL_SIZE];
	int          mismatches  = 0;
	int          cycle_count = 0;
	bit          steady_send = 1'b0;
	bit          steady_recv = 1'b0;

	arp_resolver_cache_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= steady_recv || ($urandom_range(0, 99) >= GAP_PCT);
	end

	always @(posedge clk) begin
		response_t want;
		out_item_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = out_item_t'(m_axis_tdata);
			if (pending_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("cycle %0d: unexpected response kind %0d ip %h mac %h",
						cycle_count, m_axis_tuser, got.out_ip, got.out_mac);
			end else begin
				want = pending_responses.pop_front();
				if (m_axis_tuser !== want.kind || got !== want.data
						|| m_axis_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("cycle %0d: expected kind %0d ip %h mac %h rmac %h rip %h full %b last %b",
							cycle_count, want.kind, want.data.out_ip, want.data.out_mac,
							want.data.reply_sender_mac, want.data.reply_sender_ip,
							want.data.table_full, want.last);
						$display("          actual   kind %0d ip %h mac %h rmac %h rip %h full %b last %b pad %h",
							m_axis_tuser, got.out_ip, got.out_mac, got.reply_sender_mac,
							got.reply_sender_ip, got.table_full, m_axis_tlast, got.pad);
					end
				end
			end
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [31:0] pick_ip();
		if ($urandom_range(0, 99) < 85)
			return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.elapsed          = $urandom;
		it.request_ip       = $urandom;
		it.arp_operation    = 16'($urandom);
		it.sender_mac       = rand48();
		it.sender_ip        = $urandom;
		it.target_mac       = rand48();
		it.target_ip        = $urandom;
		it.frame_source_mac = rand48();
		return it;
	endfunction

	// returns 1 when the cache is full and the pair is dropped
	function automatic logic cache_insert(input logic [31:0] ip, input logic [47:0] mac);
		if (cache_count >= TABLE_DEPTH)
			return 1'b1;
		cache_ip[cache_count]   = ip;
		cache_mac[cache_count]  = mac;
		cache_life[cache_count] = lifetime_q;
		cache_count++;
		return 1'b0;
	endfunction

	function automatic int predict_responses(input logic [1:0] cmd, input in_item_t it);
		response_t r [2];
		int        n;
		int        hit;
		int        w;
		n    = 0;
		hit  = -1;
		r[0] = '0;
		r[1] = '0;
		case (cmd)
			CMD_TICK: begin
				// drop expired entries and pack the survivors in order
				w = 0;
				for (int i = 0; i < cache_count; i++) begin
					if (cache_life[i] >= it.elapsed) begin
						cache_ip[w]   = cache_ip[i];
						cache_mac[w]  = cache_mac[i];
						cache_life[w] = cache_life[i] - it.elapsed;
						w++;
					end
				end
				cache_count = w;
			end
			CMD_QUERY, CMD_SEND: begin
				// oldest match wins
				for (int i = cache_count - 1; i >= 0; i--)
					if (cache_ip[i] == it.request_ip)
						hit = i;
				r[0].data.out_ip = it.request_ip;
				n = 1;
				if (hit >= 0) begin
					r[0].kind = (cmd == CMD_QUERY) ? KIND_READY : KIND_SENDTO;
					if (cmd == CMD_SEND)
						r[0].data.out_mac = cache_mac[hit];
				end else begin
					r[0].kind                  = KIND_QUERY;
					r[0].data.out_mac          = BCAST_MAC;
					r[0].data.reply_sender_mac = own_mac_q;
					r[0].data.reply_sender_ip  = own_ip_q;
					if (cmd == CMD_SEND) begin
						r[1].kind        = KIND_FAIL;
						r[1].data.out_ip = it.request_ip;
						n = 2;
					end
				end
			end
			CMD_ARP: begin
				if (it.arp_operation == ARP_OP_REQUEST && it.target_ip == own_ip_q) begin
					r[0].kind                  = KIND_REPLY;
					r[0].data.out_ip           = it.target_ip;
					r[0].data.out_mac          = it.frame_source_mac;
					r[0].data.reply_sender_mac = it.sender_mac;
					r[0].data.reply_sender_ip  = it.sender_ip;
					r[0].data.table_full       = cache_insert(it.sender_ip, it.sender_mac);
					n = 1;
				end else if (it.arp_operation == ARP_OP_REPLY && it.sender_mac == own_mac_q) begin
					r[0].kind            = KIND_READY;
					r[0].data.out_ip     = it.target_ip;
					r[0].data.table_full = cache_insert(it.target_ip, it.target_mac);
					n = 1;
				end
			end
			default: ;
		endcase
		if (n > 0)
			r[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_responses = {pending_responses, r[i]};
		return n;
	endfunction

	// tvalid stays high between back-to-back requests
	task automatic send_request(input logic [1:0] cmd, input in_item_t it, output int produced);
		if (!steady_send && $urandom_range(0, 99) < GAP_PCT) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= it;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		produced = predict_responses(cmd, it);
	endtask

	// value is the elapsed count for a tick, else the ip to resolve
	task automatic send_lookup(input logic [1:0] cmd, input logic [31:0] value);
		in_item_t it;
		int       n;
		it = random_item();
		if (cmd == CMD_TICK)
			it.elapsed = value;
		else
			it.request_ip = value;
		send_request(cmd, it, n);
	endtask

	task automatic send_arp(input logic [15:0] op, input logic [47:0] smac,
			input logic [31:0] sip, input logic [47:0] tmac, input logic [31:0] tip);
		in_item_t it;
		int       n;
		it               = random_item();
		it.arp_operation = op;
		it.sender_mac    = smac;
		it.sender_ip     = sip;
		it.target_mac    = tmac;
		it.target_ip     = tip;
		send_request(CMD_ARP, it, n);
	endtask

	// a tick may still be in the scan, or an ignored packet in the emit state, after the last response
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [47:0] mac, input logic [31:0] ip,
			input logic [31:0] life);
		logic [1:0]  reg_index [3];
		logic [47:0] reg_value [3];
		reg_index[0] = CFG_OWN_MAC;
		reg_index[1] = CFG_OWN_IP;
		reg_index[2] = CFG_LIFETIME;
		reg_value[0] = mac;
		reg_value[1] = {16'd0, ip};
		reg_value[2] = {16'd0, life};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= reg_index[i];
			cfg_data  <= reg_value[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid  <= 1'b0;
		own_mac_q  = mac;
		own_ip_q   = ip;
		lifetime_q = life;
	endtask

	task automatic run_random(input int count, input logic [31:0] tick_span);
		in_item_t   it;
		logic [1:0] cmd;
		int         pick;
		int         n;
		int         done;
		done = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;
		while (done < count) begin
			it   = random_item();
			cmd  = CMD_ARP;
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				it.arp_operation = ARP_OP_REQUEST;
				it.target_ip     = own_ip_q;
				it.sender_ip     = pick_ip();
			end else if (pick < 40) begin
				it.arp_operation = ARP_OP_REPLY;
				it.sender_mac    = own_mac_q;
				it.target_ip     = pick_ip();
			end else if (pick < 55) begin
				cmd           = CMD_QUERY;
				it.request_ip = pick_ip();
			end else if (pick < 70) begin
				cmd           = CMD_SEND;
				it.request_ip = pick_ip();
			end else if (pick < 85) begin
				cmd = CMD_TICK;
				if ($urandom_range(0, 9) != 0)
					it.elapsed = $urandom_range(0, tick_span);
			end else if (pick < 92) begin
				cmd = 2'($urandom_range(0, 3));
			end else begin
				// packet that looks right but is not for this station
				it.arp_operation = $urandom_range(0, 1) ? ARP_OP_REQUEST : ARP_OP_REPLY;
			end
			send_request(cmd, it, n);
			if (n > 0 || cmd != CMD_ARP)
				done++;
		end
		wait_quiet();
	endtask

	task automatic test_basic_resolution();
		logic [31:0] own_ip;
		logic [31:0] ip_a;
		logic [47:0] mac_a;
		logic [47:0] mac_b;
		own_ip = 32'hC0A8_0001;
		ip_a   = 32'hFFFF_FFFF;
		mac_a  = BCAST_MAC;
		mac_b  = 48'h0A0B_0C0D_0E0F;
		write_config(48'd0, own_ip, LIFETIME_RST);
		send_lookup(CMD_QUERY, ip_a);
		send_lookup(CMD_SEND, ip_a);
		send_arp(ARP_OP_REQUEST, mac_a, ip_a, rand48(), own_ip);
		send_lookup(CMD_QUERY, ip_a);
		// duplicate ip with a second mac, lookup keeps the older one
		send_arp(ARP_OP_REPLY, 48'd0, $urandom, mac_b, ip_a);
		send_lookup(CMD_SEND, ip_a);
		send_arp(ARP_OP_OTHER, 48'd0, $urandom, mac_b, own_ip);
		send_arp(ARP_OP_REQUEST, mac_b, ip_a, mac_b, 32'd0);
		send_arp(ARP_OP_REPLY, mac_a, ip_a, mac_b, ip_a);
		// remaining life equal to elapsed survives at zero
		send_lookup(CMD_TICK, LIFETIME_RST);
		send_lookup(CMD_TICK, 32'd0);
		send_lookup(CMD_QUERY, ip_a);
		send_lookup(CMD_TICK, 32'd1);
		send_lookup(CMD_SEND, ip_a);
		send_lookup(CMD_TICK, 32'hFFFF_FFFF);
		send_lookup(CMD_QUERY, 32'd0);
		wait_quiet();
	endtask

	task automatic test_zero_lifetime();
		logic [31:0] ip_c;
		logic [47:0] mac_c;
		ip_c  = 32'h1234_5678;
		mac_c = 48'h8000_0000_0001;
		write_config(48'h0A0B_0C0D_0E0F, 32'd0, 32'd0);
		send_arp(ARP_OP_REQUEST, mac_c, ip_c, rand48(), 32'd0);
		send_lookup(CMD_TICK, 32'd0);
		send_lookup(CMD_SEND, ip_c);
		send_lookup(CMD_TICK, 32'd1);
		send_lookup(CMD_QUERY, ip_c);
		wait_quiet();
	endtask

	task automatic test_random_mixed();
		write_config(rand48(), $urandom, LIFETIME_RST);
		run_random(150, 60);
	endtask

	// long life and short ticks fill the cache, no idling on either side
	task automatic test_random_full_table();
		steady_send = 1'b1;
		steady_recv = 1'b1;
		write_config(BCAST_MAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(150, 100);
		steady_send = 1'b0;
		steady_recv = 1'b0;
	endtask

	task automatic test_random_short_life();
		write_config(48'd0, 32'd0, $urandom_range(0, 20));
		run_random(150, 25);
	endtask

	task automatic test_random_config();
		for (int i = 0; i < 3; i++) begin
			write_config(rand48(), $urandom, $urandom_range(1, 1000));
			run_random(50, 400);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_resolution();
		test_zero_lifetime();
		test_random_mixed();
		test_random_full_table();
		test_random_short_life();
		test_random_config();
		wait_quiet();
		if (mismatches == 0 && pending_responses.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/arc_pkg.sv
hw/rtl/arc_cell.sv
hw/rtl/arc_chain.sv
hw/rtl/arp_resolver_cache_top.sv
hw/rtl/arc_checker.sv
test/tb.sv
